// File: src/csb_pkg.sv
// ----------------------------------------------------------------------------
// csb_pkg: shared types and constants of the cross stencil blur
// Frame limits, command and register codes, word formats and the words
// passed between the front end, the line stores, the queue and the back end.
// ----------------------------------------------------------------------------
package csb_pkg;

	// Frame limits and derived widths.
	localparam int MAX_COLS = 1024;
	localparam int MAX_ROWS = 1024;
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int CNT_W    = 11;
	localparam int PIX_W    = 8;
	localparam int SUM_W    = 11;

	// Input command codes.
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// Configuration register indexes.
	localparam int IDX_W = 1;
	localparam logic [IDX_W-1:0] REG_ROW_COUNT = 1'b0;
	localparam logic [IDX_W-1:0] REG_COL_COUNT = 1'b1;

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// Division by five as multiply by 1639 and shift by 13 (exact below 2730).
	localparam logic [SUM_W-1:0] RECIP_5     = 11'd1639;
	localparam int               RECIP_SHIFT = 13;
	localparam int               PROD_W      = 2 * SUM_W;

	typedef struct packed {
		logic             cmd;
		logic [PIX_W-1:0] pixel_in;
	} in_word_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             row_end;
		logic             frame_end;
	} out_word_t;

	// Line store request issued when an item is accepted.
	typedef struct packed {
		logic             en;
		logic             pix;
		logic [COL_W-1:0] addr;
		logic [PIX_W-1:0] px;
	} mem_req_t;

	// Classified item held in stage one until the line store data arrives.
	typedef struct packed {
		logic             valid;
		logic             interior;
		logic             row_end;
		logic             frame_end;
		logic [PIX_W-1:0] px;
	} stage_t;

	// Queue entry: five-point sum plus two, or the pass-through pixel.
	typedef struct packed {
		logic [SUM_W-1:0] value;
		logic             interior;
		logic             row_end;
		logic             frame_end;
	} entry_t;

	// A count of zero means one; anything above the limit means the limit.
	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
			input logic [CNT_W-1:0] maxv);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// File: src/csb_front.sv
// ----------------------------------------------------------------------------
// csb_front: input acceptance and classification
// Keeps the frame geometry and the input and output positions, decides for
// each word whether it yields a result and whether that result is filtered,
// and issues the line store access.
// ----------------------------------------------------------------------------
module csb_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [csb_pkg::IDX_W-1:0]   cfg_index,
	input  logic [csb_pkg::CNT_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  csb_pkg::in_word_t           in_word,
	input  logic [csb_pkg::QUEUE_CW-1:0] q_count,
	output csb_pkg::mem_req_t           mem_req,
	output csb_pkg::stage_t             st_s1
);

	logic [csb_pkg::ROW_W-1:0] in_row_q, out_row_q;
	logic [csb_pkg::COL_W-1:0] in_col_q, out_col_q;
	logic                      drain_pend_q;
	logic [csb_pkg::CNT_W-1:0] row_count_q, col_count_q;

	logic                      accept, is_drain, restart, emit;
	logic [csb_pkg::ROW_W-1:0] row_i, orow;
	logic [csb_pkg::COL_W-1:0] col_i, ocol;
	logic [csb_pkg::CNT_W-1:0] row_i_nx, col_i_nx, orow_nx, ocol_nx;
	logic                      last_col, last_row, in_last_col, in_last_row, interior;

	// Room is needed for the word in stage one and the one accepted now.
	assign in_stall = ({1'b0, q_count} + (csb_pkg::QUEUE_CW + 1)'(st_s1.valid))
		>= (csb_pkg::QUEUE_CW + 1)'(csb_pkg::QUEUE_DEPTH);
	assign accept = in_valid && !in_stall;

	// Positions as seen by this word; a pixel after a finished frame restarts.
	always_comb begin
		is_drain = (in_word.cmd == csb_pkg::CMD_DRAIN);
		restart  = !is_drain && drain_pend_q;
		row_i    = restart ? '0 : in_row_q;
		col_i    = restart ? '0 : in_col_q;
		orow     = restart ? '0 : out_row_q;
		ocol     = restart ? '0 : out_col_q;
		row_i_nx = {1'b0, row_i} + csb_pkg::CNT_W'(1);
		col_i_nx = {1'b0, col_i} + csb_pkg::CNT_W'(1);
		orow_nx  = {1'b0, orow} + csb_pkg::CNT_W'(1);
		ocol_nx  = {1'b0, ocol} + csb_pkg::CNT_W'(1);
		emit     = is_drain ? drain_pend_q : (row_i != '0);
		last_col = ocol_nx >= col_count_q;
		last_row = orow_nx >= row_count_q;
		in_last_col = col_i_nx >= col_count_q;
		in_last_row = row_i_nx >= row_count_q;
		interior = !is_drain && (orow != '0) && (orow_nx < row_count_q)
			&& (col_i != '0) && (col_i_nx < col_count_q);
	end

	// Line store access: drain ticks read the held row at the output column.
	always_comb begin
		mem_req.en   = accept;
		mem_req.pix  = accept && !is_drain;
		mem_req.addr = is_drain ? ocol : col_i;
		mem_req.px   = in_word.pixel_in;
	end

	// Geometry and positions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q  <= csb_pkg::CNT_W'(csb_pkg::MAX_ROWS);
			col_count_q  <= csb_pkg::CNT_W'(csb_pkg::MAX_COLS);
			in_row_q     <= '0;
			in_col_q     <= '0;
			out_row_q    <= '0;
			out_col_q    <= '0;
			drain_pend_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				csb_pkg::REG_ROW_COUNT: row_count_q <= csb_pkg::clamp_count(cfg_data,
					csb_pkg::CNT_W'(csb_pkg::MAX_ROWS));
				csb_pkg::REG_COL_COUNT: col_count_q <= csb_pkg::clamp_count(cfg_data,
					csb_pkg::CNT_W'(csb_pkg::MAX_COLS));
				default: ;
			endcase
			in_row_q     <= '0;
			in_col_q     <= '0;
			out_row_q    <= '0;
			out_col_q    <= '0;
			drain_pend_q <= 1'b0;
		end else if (accept) begin
			// Output position moves with every emitted result.
			if (emit) begin
				if (last_col) begin
					out_col_q <= '0;
					out_row_q <= last_row ? '0 : orow_nx[csb_pkg::ROW_W-1:0];
				end else begin
					out_col_q <= ocol_nx[csb_pkg::COL_W-1:0];
					out_row_q <= orow;
				end
			end else begin
				out_col_q <= ocol;
				out_row_q <= orow;
			end
			if (is_drain) begin
				if (emit && last_col && last_row) begin
					drain_pend_q <= 1'b0;
				end
			end else begin
				// Input position; the last pixel of a frame waits for drain ticks.
				if (in_last_col) begin
					in_col_q <= '0;
					in_row_q <= in_last_row ? '0 : row_i_nx[csb_pkg::ROW_W-1:0];
					drain_pend_q <= in_last_row;
				end else begin
					in_col_q <= col_i_nx[csb_pkg::COL_W-1:0];
					in_row_q <= row_i;
					drain_pend_q <= 1'b0;
				end
			end
		end
	end

	// Stage one holds the classification until the line store data arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
		end else begin
			st_s1.valid <= accept && emit;
			if (accept) begin
				st_s1.interior  <= interior;
				st_s1.row_end   <= last_col;
				st_s1.frame_end <= last_col && last_row;
				st_s1.px        <= in_word.pixel_in;
			end
		end
	end

endmodule

// File: src/csb_lines.sv
// ----------------------------------------------------------------------------
// csb_lines: line stores and five-point sum
// Holds the two previous rows, reads the upper, center and right samples of
// each accepted word, moves the center sample to the upper row in the next
// cycle and forms the queue entry.
// ----------------------------------------------------------------------------
module csb_lines (
	input  logic              clk,
	input  logic              arst_n,
	input  csb_pkg::mem_req_t mem_req,
	input  csb_pkg::stage_t   st_s1,
	output logic              q_push,
	output csb_pkg::entry_t   q_entry
);

	logic [csb_pkg::PIX_W-1:0] upper_mem  [csb_pkg::MAX_COLS];
	logic [csb_pkg::PIX_W-1:0] middle_mem [csb_pkg::MAX_COLS];

	logic [csb_pkg::PIX_W-1:0] up_s1, ctr_s1, right_s1;
	logic [csb_pkg::COL_W-1:0] addr_s1;
	logic [csb_pkg::COL_W-1:0] addr_right;
	logic                      pix_s1;
	logic [csb_pkg::PIX_W-1:0] left_q;
	logic [csb_pkg::SUM_W-1:0] sum;

	assign addr_right = mem_req.addr + csb_pkg::COL_W'(1);

	// Middle row: center and right reads, new pixel written over the center.
	always_ff @(posedge clk) begin
		if (mem_req.en) begin
			ctr_s1   <= middle_mem[mem_req.addr];
			right_s1 <= middle_mem[addr_right];
			if (mem_req.pix) begin
				middle_mem[mem_req.addr] <= mem_req.px;
			end
		end
	end

	// Upper row: read now, and the old center sample written back in the next cycle.
	always_ff @(posedge clk) begin
		if (mem_req.en) begin
			up_s1 <= upper_mem[mem_req.addr];
		end
		if (pix_s1) begin
			upper_mem[addr_s1] <= ctr_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_req.en) begin
			addr_s1 <= mem_req.addr;
		end
	end

	// The left sample is the center sample of the previous pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1 <= 1'b0;
			left_q <= '0;
		end else begin
			pix_s1 <= mem_req.pix;
			if (pix_s1) begin
				left_q <= ctr_s1;
			end
		end
	end

	// Sum with the rounding offset already added.
	assign sum = csb_pkg::SUM_W'(up_s1) + csb_pkg::SUM_W'(ctr_s1) + csb_pkg::SUM_W'(left_q)
		+ csb_pkg::SUM_W'(right_s1) + csb_pkg::SUM_W'(st_s1.px) + csb_pkg::SUM_W'(2);

	always_comb begin
		q_push            = st_s1.valid;
		q_entry.value     = st_s1.interior ? sum : csb_pkg::SUM_W'(ctr_s1);
		q_entry.interior  = st_s1.interior;
		q_entry.row_end   = st_s1.row_end;
		q_entry.frame_end = st_s1.frame_end;
	end

endmodule

// File: src/csb_fifo.sv
// ----------------------------------------------------------------------------
// csb_fifo: queue between front and back end
// A short first-in first-out queue of pending results so that the output
// side can stall without holding up the line store reads.
// ----------------------------------------------------------------------------
module csb_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  csb_pkg::entry_t              push_entry,
	input  logic                         pop,
	output logic                         not_empty,
	output csb_pkg::entry_t              head,
	output logic [csb_pkg::QUEUE_CW-1:0] count
);

	csb_pkg::entry_t             slots_q [csb_pkg::QUEUE_DEPTH];
	logic [csb_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [csb_pkg::QUEUE_CW-1:0] count_q;

	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + csb_pkg::QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + csb_pkg::QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + csb_pkg::QUEUE_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - csb_pkg::QUEUE_CW'(1);
			end
		end
	end

endmodule

// File: src/csb_back.sv
// ----------------------------------------------------------------------------
// csb_back: rounding divide and output register
// Takes queue entries, divides filtered sums by five through a reciprocal
// multiply and presents the result word in the output register.
// ----------------------------------------------------------------------------
module csb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_not_empty,
	input  csb_pkg::entry_t     q_head,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output csb_pkg::out_word_t  out_word
);

	logic                       out_valid_q;
	csb_pkg::out_word_t         out_word_q;
	logic [csb_pkg::PROD_W-1:0] prod;
	logic [csb_pkg::PIX_W-1:0]  pixel;

	// Load a new word whenever the register is empty or being taken.
	assign q_pop = q_not_empty && (!out_valid_q || !out_stall);

	assign prod  = q_head.value * csb_pkg::RECIP_5;
	assign pixel = q_head.interior ? prod[csb_pkg::RECIP_SHIFT +: csb_pkg::PIX_W]
		: q_head.value[csb_pkg::PIX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_word_q.pixel_out <= pixel;
			out_word_q.row_end   <= q_head.row_end;
			out_word_q.frame_end <= q_head.frame_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

// File: src/cross_stencil_blur.sv
// ----------------------------------------------------------------------------
// cross_stencil_blur: five-point cross mean filter on a grey pixel stream
// Pixels enter in raster order and the filtered frame leaves in raster order
// one row behind; border pixels pass unchanged and interior pixels become the
// rounded mean of themselves and their four neighbors. The block takes one
// word per clock unless it stalls and delivers one result per clock unless
// the output is held off. The middle line store serves the reads and the
// write of a word in the same cycle; the upper one is written with the old
// center sample after its read. The input stalls only when stage one and
// the four-entry queue together hold four words, which happens while the
// output is held off. A result passes from stage one, which registers the
// line store reads, through the queue to the output register. The first
// row of a frame gives no results; after the last pixel, drain ticks push
// out the held last row. Writing row_count or col_count restarts the frame.
// The line stores are not cleared after reset and need no sweep.
// ----------------------------------------------------------------------------
module cross_stencil_blur (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [csb_pkg::IDX_W-1:0] cfg_index,
	input  logic [csb_pkg::CNT_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  csb_pkg::in_word_t         in_word,
	output logic                      out_valid,
	input  logic                      out_stall,
	output csb_pkg::out_word_t        out_word
);

	csb_pkg::mem_req_t            mem_req;
	csb_pkg::stage_t              st_s1;
	logic                         q_push, q_pop, q_not_empty;
	csb_pkg::entry_t              q_entry, q_head;
	logic [csb_pkg::QUEUE_CW-1:0] q_count;

	// Front end: accepts and classifies words.
	csb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.q_count   (q_count),
		.mem_req   (mem_req),
		.st_s1     (st_s1)
	);

	// Line stores and sum.
	csb_lines u_lines (
		.clk     (clk),
		.arst_n  (arst_n),
		.mem_req (mem_req),
		.st_s1   (st_s1),
		.q_push  (q_push),
		.q_entry (q_entry)
	);

	// Queue between the two sides.
	csb_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.not_empty  (q_not_empty),
		.head       (q_head),
		.count      (q_count)
	);

	// Back end: divide and output register.
	csb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_word    (out_word)
	);

	// The stall rule must keep the queue from ever receiving a word when full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && (q_count == csb_pkg::QUEUE_CW'(csb_pkg::QUEUE_DEPTH))))
		else $error("queue written while full");

	// A word in stage one always comes from an accept in the previous cycle.
	a_s1_origin: assert property (@(posedge clk) disable iff (!arst_n)
		st_s1.valid |-> $past(in_valid && !in_stall))
		else $error("stage one valid without an accepted word");

	// The last pixel of a frame is also the last of its row.
	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_word.frame_end || out_word.row_end))
		else $error("frame end without row end");

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the cross stencil blur
// Streams grey frames through the filter over the valid/stall channels and
// compares every output word with a cycle-free prediction of the blurred
// frame. Covers border pass-through, rounded five-point means, drain ticks,
// restarts by register writes, clamped counts, the tallest frame and
// output back-pressure, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 200;
	localparam int MAX_REPORTS   = 50;
	localparam int STENCIL_TAPS  = 5;
	localparam int ROUND_BIAS    = 2;
	localparam int WORDS_PER_MODE = 50;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          cfg_wr_en = 1'b0;
	logic [csb_pkg::IDX_W-1:0]     cfg_index = '0;
	logic [csb_pkg::CNT_W-1:0]     cfg_data  = '0;
	logic                          in_valid  = 1'b0;
	logic                          in_stall;
	csb_pkg::in_word_t             in_word   = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	csb_pkg::out_word_t            out_word;

	// Idling control and bookkeeping.
	int gap_pct         = 0;
	int stall_pct       = 0;
	bit hold_start      = 1'b0;
	int hold_left       = 0;
	int cycle_count     = 0;
	int mismatches      = 0;
	int effective_items = 0;

	// Predicted filter state.
	logic [csb_pkg::PIX_W-1:0] line_above [csb_pkg::MAX_COLS];
	logic [csb_pkg::PIX_W-1:0] line_mid [csb_pkg::MAX_COLS];
	logic [csb_pkg::ROW_W-1:0] wr_row, rd_row;
	logic [csb_pkg::COL_W-1:0] wr_col, rd_col;
	logic [csb_pkg::PIX_W-1:0] prev_above;
	bit                        tail_pending;
	int                        frame_rows, frame_cols;
	csb_pkg::out_word_t        expected_pixels [$];

	cross_stencil_blur DUT (
		.clk,
		.arst_n,
		.cfg_wr_en,
		.cfg_index,
		.cfg_data,
		.in_valid,
		.in_stall,
		.in_word,
		.out_valid,
		.out_stall,
		.out_word
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
	end

	initial begin : watchdog
		wait (cycle_count >= LIMIT_CYCLES);
		$display("*** FAILED ***");
		$finish;
	end

	// A register value of zero counts as one; values above the limit saturate.
	function automatic int effective_count(input logic [csb_pkg::CNT_W-1:0] v,
			input int limit);
		if (v == '0) begin
			return 1;
		end
		if (int'(v) > limit) begin
			return limit;
		end
		return int'(v);
	endfunction

	function automatic void restart_positions();
		wr_row = '0;
		wr_col = '0;
		rd_row = '0;
		rd_col = '0;
		tail_pending = 1'b0;
	endfunction

	// Queue one output pixel at the current output position; true on frame end.
	function automatic bit queue_pixel(input logic [csb_pkg::PIX_W-1:0] v);
		csb_pkg::out_word_t w;
		bit col_done;
		bit row_done;
		col_done = int'(rd_col) + 1 >= frame_cols;
		row_done = int'(rd_row) + 1 >= frame_rows;
		w.pixel_out = v;
		w.row_end = col_done;
		w.frame_end = col_done && row_done;
		expected_pixels.push_back(w);
		if (col_done) begin
			rd_col = '0;
			rd_row = row_done ? '0 : rd_row + 1'b1;
		end else begin
			rd_col = rd_col + 1'b1;
		end
		return col_done && row_done;
	endfunction

	// Advance the predicted filter by one accepted word.
	task automatic blur_step(input csb_pkg::in_word_t w);
		int c;
		int up_px;
		int mid_px;
		int right_px;
		int total;
		bit interior;
		logic [csb_pkg::PIX_W-1:0] value;
		if (w.cmd == csb_pkg::CMD_DRAIN) begin
			// A drain tick with nothing held is simply ignored.
			if (tail_pending) begin
				effective_items++;
				if (queue_pixel(line_mid[rd_col])) begin
					tail_pending = 1'b0;
				end
			end
			return;
		end
		effective_items++;
		// A pixel arriving while the last row is still held drops that row.
		if (tail_pending) begin
			restart_positions();
		end
		c = int'(wr_col);
		up_px = line_above[c];
		mid_px = line_mid[c];
		right_px = (c + 1 < csb_pkg::MAX_COLS) ? line_mid[c + 1] : 0;
		total = up_px + mid_px + int'(prev_above) + right_px + int'(w.pixel_in) + ROUND_BIAS;
		line_above[c] = mid_px;
		line_mid[c] = w.pixel_in;
		prev_above = mid_px;
		// The first input row of a frame produces nothing.
		if (wr_row != '0) begin
			interior = rd_row != '0 && int'(rd_row) + 1 < frame_rows && c >= 1 &&
				c + 1 < frame_cols;
			value = interior ? csb_pkg::PIX_W'(total / STENCIL_TAPS)
				: csb_pkg::PIX_W'(mid_px);
			void'(queue_pixel(value));
		end
		if (int'(wr_col) + 1 >= frame_cols) begin
			wr_col = '0;
			if (int'(wr_row) + 1 >= frame_rows) begin
				wr_row = '0;
				tail_pending = 1'b1;
			end else begin
				wr_row = wr_row + 1'b1;
			end
		end else begin
			wr_col = wr_col + 1'b1;
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		// Only the first few mismatches are printed; all of them are counted.
		if (mismatches < MAX_REPORTS) begin
			$display("cycle %0d: %s mismatch, got %0d, expected %0d", cycle_count, what, got, want);
		end
		mismatches++;
	endtask

	// Offer one word, with a random gap before it, and wait until it is taken.
	task automatic send_word(input logic cmd, input logic [csb_pkg::PIX_W-1:0] px);
		csb_pkg::in_word_t w;
		w.cmd = cmd;
		w.pixel_in = px;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		blur_step(w);
	endtask

	// Stop offering words and let every expected word come out.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [csb_pkg::IDX_W-1:0] idx,
			input logic [csb_pkg::CNT_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == csb_pkg::REG_ROW_COUNT) begin
			frame_rows = effective_count(data, csb_pkg::MAX_ROWS);
		end else begin
			frame_cols = effective_count(data, csb_pkg::MAX_COLS);
		end
		restart_positions();
		@(posedge clk);
	endtask

	// Pixel values lean toward the black and white extremes now and then.
	function automatic logic [csb_pkg::PIX_W-1:0] pick_pixel();
		int r;
		r = $urandom_range(9);
		if (r == 0) begin
			return '0;
		end
		if (r == 1) begin
			return '1;
		end
		return csb_pkg::PIX_W'($urandom);
	endfunction

	// Output side: random stalls, or a long hold when one is requested.
	always @(posedge clk) begin : drive_out_stall
		if (hold_start) begin
			hold_left = HOLD_CYCLES;
			hold_start = 1'b0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Compare each delivered word with the oldest prediction.
	always @(posedge clk) begin : check_words
		csb_pkg::out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch("unexpected word, pixel_out", out_word.pixel_out, -1);
			end else begin
				want = expected_pixels.pop_front();
				if (out_word.pixel_out !== want.pixel_out) begin
					report_mismatch("pixel_out", out_word.pixel_out, want.pixel_out);
				end
				if (out_word.row_end !== want.row_end) begin
					report_mismatch("row_end", out_word.row_end, want.row_end);
				end
				if (out_word.frame_end !== want.frame_end) begin
					report_mismatch("frame_end", out_word.frame_end, want.frame_end);
				end
			end
		end
	end

	// Hand-picked frames: extremes, ignored drains, dropped tail, tiny frames.
	task automatic test_directed_cases();
		int ramp [12] = '{0, 255, 255, 0, 255, 255, 255, 255, 255, 255, 255, 0};
		int thin [5] = '{255, 0, 255, 0, 1};
		gap_pct = 0;
		stall_pct = 0;
		write_reg(csb_pkg::REG_ROW_COUNT, csb_pkg::CNT_W'(3));
		write_reg(csb_pkg::REG_COL_COUNT, csb_pkg::CNT_W'(4));
		send_word(csb_pkg::CMD_DRAIN, '1);
		foreach (ramp[i]) begin
			send_word(csb_pkg::CMD_PIXEL, csb_pkg::PIX_W'(ramp[i]));
		end
		// Part of the last row, then a pixel that abandons the rest of it.
		send_word(csb_pkg::CMD_DRAIN, '0);
		send_word(csb_pkg::CMD_DRAIN, '1);
		send_word(csb_pkg::CMD_PIXEL, csb_pkg::PIX_W'(128));
		wait_idle();
		// A zero row count means a single row: everything comes out on drain.
		write_reg(csb_pkg::REG_ROW_COUNT, '0);
		write_reg(csb_pkg::REG_COL_COUNT, csb_pkg::CNT_W'(5));
		foreach (thin[i]) begin
			send_word(csb_pkg::CMD_PIXEL, csb_pkg::PIX_W'(thin[i]));
		end
		repeat (6) send_word(csb_pkg::CMD_DRAIN, csb_pkg::PIX_W'($urandom));
		wait_idle();
	endtask

	// Hold the output long enough for the block to stop taking input.
	task automatic test_output_backpressure();
		gap_pct = 0;
		stall_pct = 0;
		write_reg(csb_pkg::REG_ROW_COUNT, csb_pkg::CNT_W'(5));
		write_reg(csb_pkg::REG_COL_COUNT, csb_pkg::CNT_W'(6));
		hold_start = 1'b1;
		repeat (30) send_word(csb_pkg::CMD_PIXEL, pick_pixel());
		repeat (6) send_word(csb_pkg::CMD_DRAIN, csb_pkg::PIX_W'($urandom));
		wait_idle();
	endtask

	// Random small frames, mostly complete, some cut short, with stray drains.
	task automatic test_random_stream(input int target);
		int start;
		int rows_data;
		int cols_data;
		int rows;
		int cols;
		int shape;
		int n_pix;
		int n_drain;
		start = effective_items;
		while (effective_items - start < target) begin
			wait_idle();
			rows_data = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 6);
			cols_data = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 10);
			if ($urandom_range(1) == 0) begin
				write_reg(csb_pkg::REG_ROW_COUNT, csb_pkg::CNT_W'(rows_data));
				write_reg(csb_pkg::REG_COL_COUNT, csb_pkg::CNT_W'(cols_data));
			end else begin
				write_reg(csb_pkg::REG_COL_COUNT, csb_pkg::CNT_W'(cols_data));
				write_reg(csb_pkg::REG_ROW_COUNT, csb_pkg::CNT_W'(rows_data));
			end
			rows = (rows_data == 0) ? 1 : rows_data;
			cols = (cols_data == 0) ? 1 : cols_data;
			repeat ($urandom_range(1, 3)) begin
				shape = $urandom_range(99);
				n_pix = rows * cols;
				n_drain = cols;
				if (shape < 10) begin
					n_pix = $urandom_range(1, n_pix);
				end else if (shape < 20) begin
					n_drain = $urandom_range(0, cols - 1);
				end else if (shape >= 94) begin
					n_drain += $urandom_range(1, 3);
				end
				repeat (n_pix) begin
					if ($urandom_range(19) == 0) begin
						send_word(csb_pkg::CMD_DRAIN, csb_pkg::PIX_W'($urandom));
					end
					send_word(csb_pkg::CMD_PIXEL, pick_pixel());
				end
				repeat (n_drain) send_word(csb_pkg::CMD_DRAIN, csb_pkg::PIX_W'($urandom));
			end
		end
		wait_idle();
	endtask

	// Largest row count, given above the limit, with one column.
	task automatic test_extreme_sizes();
		gap_pct = 0;
		stall_pct = 0;
		write_reg(csb_pkg::REG_ROW_COUNT, '1);
		write_reg(csb_pkg::REG_COL_COUNT, '0);
		repeat (csb_pkg::MAX_ROWS) send_word(csb_pkg::CMD_PIXEL, pick_pixel());
		send_word(csb_pkg::CMD_DRAIN, csb_pkg::PIX_W'($urandom));
		wait_idle();
	endtask

	initial begin
		foreach (line_above[i]) begin
			line_above[i] = '0;
			line_mid[i] = '0;
		end
		prev_above = '0;
		frame_rows = csb_pkg::MAX_ROWS;
		frame_cols = csb_pkg::MAX_COLS;
		restart_positions();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_output_backpressure();
		gap_pct = 26;
		stall_pct = 64;
		test_random_stream(WORDS_PER_MODE);
		gap_pct = 64;
		stall_pct = 26;
		test_random_stream(WORDS_PER_MODE);
		gap_pct = 0;
		stall_pct = 0;
		test_random_stream(WORDS_PER_MODE);
		test_extreme_sizes();
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
